// ===== rtl/ldnw_pkg.sv =====
`timescale 1ns / 1ps
// Package for the LCD decimal number writer.
// Holds the shared types, LCD byte codes and digit weight table; no dependencies.
package ldnw_pkg;

  localparam int NumW    = 17;
  localparam int DigitW  = 4;
  localparam int PlaceW  = 3;
  localparam int ByteW   = 8;

  // Command codes of the input word.
  localparam logic CMD_INIT    = 1'b0;
  localparam logic CMD_DISPLAY = 1'b1;

  // Register select codes of a result word.
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  localparam logic [NumW-1:0]   NUM_MAX    = NumW'(99999);
  localparam logic [ByteW-1:0]  LCD_FUNC_SET = 8'h38;
  localparam logic [ByteW-1:0]  LCD_CLEAR    = 8'h01;
  localparam logic [ByteW-1:0]  LCD_DISP_ON  = 8'h0E;
  localparam logic [ByteW-1:0]  LCD_ENTRY    = 8'h06;
  localparam logic [ByteW-1:0]  ASCII_ZERO   = 8'h30;
  localparam logic [PlaceW-1:0] INIT_LAST    = PlaceW'(3);
  localparam logic [PlaceW-1:0] DIGIT_LAST   = PlaceW'(4);
  localparam logic [DigitW-1:0] DIGIT_MAX    = DigitW'(9);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;       // load the number and clear the counters
    logic sub;         // one subtraction step of the current place
    logic emit_init;   // load a set-up write into the output register
    logic emit_digit;  // load a digit write into the output register
    logic step_place;  // move to the next place, clear the digit
  } ldnw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_sub;     // the current place takes one more subtraction
    logic init_last;   // place counter is at the last set-up write
    logic digit_last;  // place counter is at the units digit
    logic out_free;    // the output register can take a word this cycle
  } ldnw_status_t;

  // Set-up sequence for the LCD controller.
  function automatic logic [ByteW-1:0] init_byte(input logic [1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      2'd0:    b = LCD_FUNC_SET;
      2'd1:    b = LCD_CLEAR;
      2'd2:    b = LCD_DISP_ON;
      default: b = LCD_ENTRY;
    endcase
    return b;
  endfunction

  // Decimal weight of each digit place, most significant first.
  function automatic logic [NumW-1:0] place_weight(input logic [PlaceW-1:0] place);
    logic [NumW-1:0] w;
    case (place)
      3'd0:    w = NumW'(10000);
      3'd1:    w = NumW'(1000);
      3'd2:    w = NumW'(100);
      3'd3:    w = NumW'(10);
      default: w = NumW'(1);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ldnw_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and result words.
// Depends on ldnw_pkg for field widths.
interface ldnw_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [ldnw_pkg::NumW-1:0] number;

  modport source (output valid, output cmd, output number, input ready);
  modport sink   (input valid, input cmd, input number, output ready);
endinterface

interface ldnw_out_if;
  logic                       valid;
  logic                       ready;
  logic                       register_select;
  logic [ldnw_pkg::ByteW-1:0] lcd_byte;
  logic                       wait_busy;
  logic                       last;

  modport source (output valid, output register_select, output lcd_byte,
                  output wait_busy, output last, input ready);
  modport sink   (input valid, input register_select, input lcd_byte,
                  input wait_busy, input last, output ready);
endinterface

// ===== rtl/ldnw_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the LCD decimal number writer.
// Depends on ldnw_pkg for the command and status structs.
module ldnw_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_cmd,
  output logic                   in_ready,
  input  ldnw_pkg::ldnw_status_t status,
  output ldnw_pkg::ldnw_cmd_t    ctrl
);
  import ldnw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_DIGIT
  } state_t;

  state_t state_r, state_nxt;

  // Ready only between commands.
  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.start = 1'b1;
          state_nxt  = (in_cmd == CMD_INIT) ? S_INIT : S_DIGIT;
        end
      end
      S_INIT: begin
        if (status.out_free) begin
          ctrl.emit_init  = 1'b1;
          ctrl.step_place = 1'b1;
          if (status.init_last) state_nxt = S_IDLE;
        end
      end
      S_DIGIT: begin
        // Subtract until the place is done, then emit its digit.
        if (status.can_sub) begin
          ctrl.sub = 1'b1;
        end else if (status.out_free) begin
          ctrl.emit_digit = 1'b1;
          ctrl.step_place = 1'b1;
          if (status.digit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/ldnw_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the LCD decimal number writer: remainder, digit and place
// counters, and the output word register. Depends on ldnw_pkg.
module ldnw_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ldnw_pkg::NumW-1:0]  in_number,
  input  ldnw_pkg::ldnw_cmd_t        ctrl,
  output ldnw_pkg::ldnw_status_t     status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_register_select,
  output logic [ldnw_pkg::ByteW-1:0] out_lcd_byte,
  output logic                       out_wait_busy,
  output logic                       out_last
);
  import ldnw_pkg::*;

  logic [NumW-1:0]   rest_r;
  logic [DigitW-1:0] digit_r;
  logic [PlaceW-1:0] place_r;
  logic [NumW-1:0]   weight;
  logic              valid_r;
  logic              rs_r, busy_r, last_r;
  logic [ByteW-1:0]  byte_r;
  logic              emit;

  assign weight = place_weight(place_r);
  assign emit   = ctrl.emit_init | ctrl.emit_digit;

  // Status back to the controller.
  assign status.can_sub    = (rest_r >= weight) && (digit_r < DIGIT_MAX);
  assign status.init_last  = (place_r == INIT_LAST);
  assign status.digit_last = (place_r == DIGIT_LAST);
  assign status.out_free   = !valid_r || out_ready;

  // Remainder, digit and place counters.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rest_r  <= (in_number > NUM_MAX) ? NUM_MAX : in_number;
      digit_r <= '0;
      place_r <= '0;
    end else if (ctrl.sub) begin
      rest_r  <= rest_r - weight;
      digit_r <= digit_r + DigitW'(1);
    end else if (ctrl.step_place) begin
      digit_r <= '0;
      place_r <= place_r + PlaceW'(1);
    end
  end

  // Output word register; held until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_init) begin
      rs_r   <= RS_COMMAND;
      byte_r <= init_byte(place_r[1:0]);
      busy_r <= (place_r != '0);
      last_r <= (place_r == INIT_LAST);
    end else if (ctrl.emit_digit) begin
      rs_r   <= RS_DATA;
      byte_r <= ASCII_ZERO + {{(ByteW-DigitW){1'b0}}, digit_r};
      busy_r <= 1'b1;
      last_r <= (place_r == DIGIT_LAST);
    end
  end

  assign out_valid           = valid_r;
  assign out_register_select = rs_r;
  assign out_lcd_byte        = byte_r;
  assign out_wait_busy       = busy_r;
  assign out_last            = last_r;

endmodule

// ===== rtl/lcd_decimal_number_writer_unit.sv =====
`timescale 1ns / 1ps
// An init command gives four words: one per cycle once the output is free.
// A display command subtracts the current place weight until the place is done, at most nine
// times per place, and then emits the digit once the output is free. One command at a time.
// The last word of a command may still wait in the output register while the next is taken.
// Reset (rst_n, synchronous, active low) returns the controller to idle and empties the output.
// Depends on ldnw_pkg, ldnw_if, ldnw_ctrl and ldnw_dp.
module lcd_decimal_number_writer_unit (
  input  logic       clk,
  input  logic       rst_n,
  ldnw_in_if.sink    in_ch,
  ldnw_out_if.source out_ch
);
  import ldnw_pkg::*;

  ldnw_cmd_t    ctrl;
  ldnw_status_t status;

  // Sequencer for set-up writes and digit extraction.
  ldnw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // Subtraction datapath and output register.
  ldnw_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_number           (in_ch.number),
    .ctrl                (ctrl),
    .status              (status),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_register_select (out_ch.register_select),
    .out_lcd_byte        (out_ch.lcd_byte),
    .out_wait_busy       (out_ch.wait_busy),
    .out_last            (out_ch.last)
  );

endmodule

// ===== rtl/ldnw_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the LCD decimal number writer, bound to the top level.
// Depends on ldnw_pkg for field widths.
module ldnw_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_register_select,
  input logic [ldnw_pkg::ByteW-1:0] out_lcd_byte,
  input logic                       out_wait_busy,
  input logic                       out_last
);
  import ldnw_pkg::*;

  // A stalled word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lcd_byte) &&
      $stable(out_register_select) && $stable(out_last))
    else $error("stalled output word changed");

  // One command at a time: no new word is taken right after one is.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in progress");

  // Command writes are only the set-up bytes.
  a_cmd_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_register_select == RS_COMMAND) |->
      out_lcd_byte == LCD_FUNC_SET || out_lcd_byte == LCD_CLEAR ||
      out_lcd_byte == LCD_DISP_ON || out_lcd_byte == LCD_ENTRY)
    else $error("unexpected command byte");

  // Data writes are ASCII digits that always wait on busy.
  a_data_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_register_select == RS_DATA) |->
      out_wait_busy && out_lcd_byte >= ASCII_ZERO && out_lcd_byte <= 8'h39)
    else $error("data write is not a digit");

  // Only the function set write skips the busy poll, and it is never last.
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_wait_busy |->
      out_lcd_byte == LCD_FUNC_SET && !out_last)
    else $error("busy poll skipped on the wrong write");

endmodule

bind lcd_decimal_number_writer_unit ldnw_checker u_ldnw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_register_select (out_ch.register_select),
  .out_lcd_byte        (out_ch.lcd_byte),
  .out_wait_busy       (out_ch.wait_busy),
  .out_last            (out_ch.last)
);

// ===== dv/lcd_decimal_number_writer_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LCD decimal number writer: drives command words, predicts
// the LCD writes each one causes and checks every result word in order under random idling.
// Depends on ldnw_pkg, ldnw_if and the lcd_decimal_number_writer_unit RTL.
module lcd_decimal_number_writer_unit_test;
  import ldnw_pkg::*;

  // One LCD write as it should leave the block.
  typedef struct {
    logic             rs;
    logic [ByteW-1:0] lcd_byte;
    logic             busy;
    logic             last;
  } lcd_write_t;

  localparam int RandomPerPhase = 120;
  localparam int DrainCycles    = 60;
  localparam int MaxReported    = 10;

  logic clk;
  logic rst_n;

  ldnw_in_if  in_ch ();
  ldnw_out_if out_ch ();

  lcd_decimal_number_writer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lcd_write_t expected_writes[$];
  int         mismatch_count;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_off_left;

  // Clock generator.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is ended here if the block stops making progress.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Works out the LCD writes that one command word should produce.
  function automatic void predict_lcd_writes(input logic cmd, input logic [NumW-1:0] number);
    logic [ByteW-1:0] setup_bytes[4];
    int               weights[5];
    int               remainder;
    int               digit;
    lcd_write_t       w;
    setup_bytes = '{LCD_FUNC_SET, LCD_CLEAR, LCD_DISP_ON, LCD_ENTRY};
    weights     = '{10000, 1000, 100, 10, 1};
    if (cmd == CMD_INIT) begin
      // Set-up sequence: only the function set goes out without a busy poll.
      for (int k = 0; k < 4; k++) begin
        w.rs       = RS_COMMAND;
        w.lcd_byte = setup_bytes[k];
        w.busy     = (k != 0);
        w.last     = (k == 3);
        expected_writes.push_back(w);
      end
    end else begin
      // Saturate, then peel off each decimal place by repeated subtraction.
      remainder = (number > NUM_MAX) ? int'(NUM_MAX) : int'(number);
      for (int k = 0; k < 5; k++) begin
        digit = 0;
        while (remainder >= weights[k] && digit < 9) begin
          remainder -= weights[k];
          digit++;
        end
        w.rs       = RS_DATA;
        w.lcd_byte = ASCII_ZERO + ByteW'(digit);
        w.busy     = 1'b1;
        w.last     = (k == 4);
        expected_writes.push_back(w);
      end
    end
  endfunction

  // Offers one command word after a random gap and records its writes once it is taken.
  task automatic send_command(input logic cmd, input logic [NumW-1:0] number);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= cmd;
    in_ch.number <= number;
    do @(posedge clk); while (!in_ch.ready);
    predict_lcd_writes(cmd, number);
  endtask

  // Lowers valid and waits until every expected write has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_writes.size() > 0) @(posedge clk);
  endtask

  // A number drawn to favour saturation, small values and place boundaries.
  function automatic logic [NumW-1:0] pick_number();
    int                sel;
    int                edges[10];
    logic [NumW-1:0]   n;
    edges = '{9, 10, 99, 100, 999, 1000, 9999, 10000, 99999, 100000};
    sel = $urandom_range(9);
    if (sel < 2)       n = NumW'($urandom_range(131071, 100000));
    else if (sel == 2) n = NumW'($urandom_range(99));
    else if (sel == 3) n = NumW'(edges[$urandom_range(9)] + $urandom_range(2) - 1);
    else               n = NumW'($urandom_range(99999));
    return n;
  endfunction

  // The set-up sequence, back to back and with display words between.
  task automatic test_init_sequence();
    send_command(CMD_INIT, '0);
    send_command(CMD_INIT, '1);
    send_command(CMD_DISPLAY, NumW'(42));
    send_command(CMD_INIT, NumW'(12345));
    wait_for_drain();
  endtask

  // Field extremes, every place boundary and saturation.
  task automatic test_number_extremes();
    int values[18];
    values = '{0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 99998, 99999,
               100000, 131071, 65536, 12345, 54321, 90909};
    foreach (values[i]) send_command(CMD_DISPLAY, NumW'(values[i]));
    wait_for_drain();
  endtask

  // Random command words under one idling pattern.
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    logic cmd;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(99) < 20) ? CMD_INIT : CMD_DISPLAY;
      send_command(cmd, pick_number());
    end
    wait_for_drain();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the input stalls.
  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 400;
    for (int i = 0; i < 20; i++) send_command(i % 5 == 0 ? CMD_INIT : CMD_DISPLAY, pick_number());
    wait_for_drain();
  endtask

  // Receiver: ready changes on the falling edge, with an optional long hold-off.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each word that leaves the block is compared with the oldest expected write.
  always @(posedge clk) begin
    lcd_write_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_writes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display("Unexpected word: rs=%0b byte=%02h busy=%0b last=%0b",
                   out_ch.register_select, out_ch.lcd_byte, out_ch.wait_busy, out_ch.last);
      end else begin
        w = expected_writes.pop_front();
        if (out_ch.register_select !== w.rs || out_ch.lcd_byte !== w.lcd_byte ||
            out_ch.wait_busy !== w.busy || out_ch.last !== w.last) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display("Mismatch: expected rs=%0b byte=%02h busy=%0b last=%0b,",
                     w.rs, w.lcd_byte, w.busy, w.last,
                     " got rs=%0b byte=%02h busy=%0b last=%0b",
                     out_ch.register_select, out_ch.lcd_byte, out_ch.wait_busy,
                     out_ch.last);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_INIT;
    in_ch.number   = '0;
    out_ch.ready   = 1'b0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_init_sequence();
    test_number_extremes();
    test_random_traffic(RandomPerPhase, 0, 0);
    test_random_traffic(RandomPerPhase, 55, 0);
    test_random_traffic(RandomPerPhase, 0, 55);
    test_random_traffic(RandomPerPhase, 10, 10);
    test_output_hold_off();

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_writes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ldnw_pkg.sv
rtl/ldnw_if.sv
rtl/ldnw_ctrl.sv
rtl/ldnw_dp.sv
rtl/lcd_decimal_number_writer_unit.sv
rtl/ldnw_checker.sv
dv/lcd_decimal_number_writer_unit_test.sv
